// File: rtl/dirw_pkg.sv
// Shared types and constants for the directory record walker.
// Used by the front, queue, back and top-level modules.
package dirw_pkg;

  localparam int POS_W     = 21;
  localparam int OFS_W     = 20;
  localparam int HDR_BYTES = 8;

  typedef struct packed {
    logic [31:0]      entry_inode;
    logic [15:0]      rec_len;
    logic [7:0]       entry_type;
    logic [7:0]       name_length;
    logic [OFS_W-1:0] name_offset;
  } dirw_rec_t;

  typedef struct packed {
    logic full;
    logic valid;
  } dirw_qstat_t;

endpackage

// File: rtl/directory_record_walker_core.sv
// Top level of the directory record walker: front end, entry queue, output stage.
// Depends on dirw_pkg, dirw_front, dirw_queue and dirw_back.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | in_data_byte[7:0], in_first_byte
//  out_    | output    | out_valid/out_stall | inode, record/name length, type, name offset
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_buffer_length[20:0]
//
// One byte per cycle while in_stall is low; a decoded entry from a record's last header
// byte passes through the queue write, then the output register, before it appears on out_.
// Reset is synchronous, active low; buffer length resets to 512.
// in_stall rises only when the QUEUE_DEPTH-entry queue is full; cfg_ready is always high.
module directory_record_walker_core import dirw_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_data_byte,
  input  logic             in_first_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      out_entry_inode,
  output logic [15:0]      out_rec_len,
  output logic [7:0]       out_entry_type,
  output logic [7:0]       out_name_length,
  output logic [OFS_W-1:0] out_name_offset,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [POS_W-1:0] cfg_buffer_length
);

  logic        acc, push, pop;
  dirw_rec_t   push_rec, head_rec, out_rec;
  dirw_qstat_t qstat;

  assign acc       = in_valid && !in_stall;
  assign in_stall  = qstat.full;
  assign cfg_ready = 1'b1;

  dirw_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_buffer_length (cfg_buffer_length),
    .acc               (acc),
    .data_byte         (in_data_byte),
    .first_byte        (in_first_byte),
    .push              (push),
    .push_rec          (push_rec)
  );

  dirw_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .stat     (qstat),
    .head_rec (head_rec)
  );

  dirw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .head_rec  (head_rec),
    .out_stall (out_stall),
    .pop       (pop),
    .out_valid (out_valid),
    .out_rec   (out_rec)
  );

  assign out_entry_inode = out_rec.entry_inode;
  assign out_rec_len     = out_rec.rec_len;
  assign out_entry_type  = out_rec.entry_type;
  assign out_name_length = out_rec.name_length;
  assign out_name_offset = out_rec.name_offset;

endmodule

// File: rtl/dirw_front.sv
// Front end: takes buffer bytes, tracks position and header window, decodes records.
// Depends on dirw_pkg; pushes decoded entries into dirw_queue.
module dirw_front import dirw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic [POS_W-1:0] cfg_buffer_length,
  input  logic             acc,
  input  logic [7:0]       data_byte,
  input  logic             first_byte,
  output logic             push,
  output dirw_rec_t        push_rec
);

  logic [POS_W-1:0] buf_len_r, buf_len_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] nrs_r, nrs_nxt;
  logic [63:0]      win_r, win_nxt;
  logic             stop_r, stop_nxt;

  logic [POS_W-1:0] p, nrs_e;
  logic [63:0]      win_e, win_new;
  logic             stop_e, active, hdr, fits, emit;
  logic [POS_W:0]   hdr_end, next_start;
  logic [POS_W+1:0] name_end;
  logic [31:0]      ino;
  logic [15:0]      rlen;
  logic [7:0]       nlen;
  logic [POS_W-1:0] name_ofs;

  always_comb begin
    p       = first_byte ? '0 : pos_r;
    nrs_e   = first_byte ? '0 : nrs_r;
    win_e   = first_byte ? '0 : win_r;
    stop_e  = first_byte ? 1'b0 : stop_r;
    active  = p < buf_len_r;
    win_new = {win_e[55:0], data_byte};
    ino     = win_new[63:32];
    rlen    = win_new[31:16];
    nlen    = win_new[7:0];
    hdr_end    = {1'b0, nrs_e} + (POS_W+1)'(HDR_BYTES - 1);
    hdr        = active && !stop_e && ({1'b0, p} == hdr_end);
    name_ofs   = nrs_e + POS_W'(HDR_BYTES);
    name_end   = {2'b0, nrs_e} + (POS_W+2)'(HDR_BYTES) + (POS_W+2)'(nlen);
    fits       = name_end <= {2'b0, buf_len_r};
    next_start = {1'b0, nrs_e} + (POS_W+1)'(rlen);
    emit       = hdr && (rlen != '0) && (ino != '0) && (nlen != '0) && fits;

    pos_nxt  = pos_r;
    nrs_nxt  = nrs_r;
    win_nxt  = win_r;
    stop_nxt = stop_r;
    if (acc) begin
      pos_nxt  = p;
      nrs_nxt  = nrs_e;
      win_nxt  = win_e;
      stop_nxt = stop_e;
      if (active) begin
        pos_nxt = p + POS_W'(1);
        win_nxt = win_new;
        if (hdr) begin
          if (rlen == '0) begin
            stop_nxt = 1'b1;
          end else if (next_start[POS_W]) begin
            stop_nxt = 1'b1;
          end else begin
            nrs_nxt = next_start[POS_W-1:0];
          end
        end
      end
    end
    buf_len_nxt = cfg_valid ? cfg_buffer_length : buf_len_r;

    push                  = acc && emit;
    push_rec.entry_inode  = ino;
    push_rec.rec_len      = rlen;
    push_rec.entry_type   = win_new[15:8];
    push_rec.name_length  = nlen;
    push_rec.name_offset  = name_ofs[OFS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_len_r <= POS_W'(512);
      pos_r     <= '0;
      nrs_r     <= '0;
      win_r     <= '0;
      stop_r    <= 1'b0;
    end else begin
      buf_len_r <= buf_len_nxt;
      pos_r     <= pos_nxt;
      nrs_r     <= nrs_nxt;
      win_r     <= win_nxt;
      stop_r    <= stop_nxt;
    end
  end

endmodule

// File: rtl/dirw_queue.sv
// Short entry queue between the front end and the output stage.
// Depends on dirw_pkg for the entry type.
module dirw_queue import dirw_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  dirw_rec_t   push_rec,
  input  logic        pop,
  output dirw_qstat_t stat,
  output dirw_rec_t   head_rec
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dirw_rec_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    stat.full  = cnt_r == CNT_W'(DEPTH);
    stat.valid = cnt_r != '0;
    head_rec   = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: rtl/dirw_back.sv
// Output stage: moves entries from the queue into the result register.
// Depends on dirw_pkg for the entry and queue status types.
module dirw_back import dirw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dirw_qstat_t qstat,
  input  dirw_rec_t   head_rec,
  input  logic        out_stall,
  output logic        pop,
  output logic        out_valid,
  output dirw_rec_t   out_rec
);

  logic      valid_r, valid_nxt;
  dirw_rec_t rec_r;
  logic      open;

  always_comb begin
    open      = !valid_r || !out_stall;
    pop       = open && qstat.valid;
    valid_nxt = open ? qstat.valid : valid_r;
    out_valid = valid_r;
    out_rec   = rec_r;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec_r <= head_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

// File: sim/directory_record_walker_core_tb.sv
// Self-checking testbench for directory_record_walker_core: byte streams of directory buffers in,
// decoded entries out, checked against an in-bench walker model. Depends on dirw_pkg and the RTL.
`timescale 1ns / 100ps

module directory_record_walker_core_tb import dirw_pkg::*; ();

  localparam int QUIET_LIMIT = 5000;

  typedef struct packed {
    logic       first;
    logic [7:0] data;
  } dir_byte_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_data_byte = '0;
  logic             in_first_byte = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [31:0]      out_entry_inode;
  logic [15:0]      out_rec_len;
  logic [7:0]       out_entry_type;
  logic [7:0]       out_name_length;
  logic [OFS_W-1:0] out_name_offset;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [POS_W-1:0] cfg_buffer_length = '0;

  directory_record_walker_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_first_byte     (in_first_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_entry_inode   (out_entry_inode),
    .out_rec_len       (out_rec_len),
    .out_entry_type    (out_entry_type),
    .out_name_length   (out_name_length),
    .out_name_offset   (out_name_offset),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_buffer_length (cfg_buffer_length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // walker state
  logic [POS_W-1:0] buf_len = POS_W'(512);
  logic [POS_W-1:0] walk_pos = '0;
  logic [POS_W-1:0] rec_start = '0;
  logic [63:0]      hdr_win = '0;
  logic             walk_stopped = 1'b0;

  dir_byte_t pending_bytes[$];
  dirw_rec_t entry_q[$];

  logic in_acc = 1'b0;
  bit   idle_on = 1'b1;
  int   src_gap = 0;
  int   snk_gap = 0;
  int   n_sent = 0;
  int   n_taken = 0;
  int   n_checked = 0;
  int   n_cfg = 0;
  int   errors = 0;
  int   quiet = 0;

  function automatic void walk_byte(logic [7:0] b, logic first);
    logic [POS_W-1:0] p;
    logic [7:0]       nlen;
    logic [15:0]      rlen;
    int unsigned      nxt;
    dirw_rec_t        e;
    if (first) begin
      walk_pos = '0;
      rec_start = '0;
      hdr_win = '0;
      walk_stopped = 1'b0;
    end
    p = walk_pos;
    if (p >= buf_len) return;
    walk_pos = p + POS_W'(1);
    hdr_win = {hdr_win[55:0], b};
    if (walk_stopped || 32'(p) != 32'(rec_start) + HDR_BYTES - 1) return;
    rlen = hdr_win[31:16];
    nlen = hdr_win[7:0];
    if (rlen == 16'd0) begin
      walk_stopped = 1'b1;
      return;
    end
    if (hdr_win[63:32] != 32'd0 && nlen != 8'd0 &&
        32'(rec_start) + HDR_BYTES + 32'(nlen) <= 32'(buf_len)) begin
      e.entry_inode = hdr_win[63:32];
      e.rec_len = rlen;
      e.entry_type = hdr_win[15:8];
      e.name_length = nlen;
      e.name_offset = OFS_W'(32'(rec_start) + HDR_BYTES);
      entry_q.insert(entry_q.size(), e);
    end
    nxt = 32'(rec_start) + 32'(rlen);
    if (nxt > 32'h1F_FFFF) walk_stopped = 1'b1;
    else rec_start = POS_W'(nxt);
  endfunction

  task automatic report(string field, longint unsigned want, longint unsigned got);
    errors++;
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
  endtask

  // driver
  always @(negedge clk) begin : drv
    dir_byte_t nb;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (!idle_on) src_gap = 0;
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        nb = pending_bytes.pop_front();
        in_valid <= 1'b1;
        in_data_byte <= nb.data;
        in_first_byte <= nb.first;
        n_sent++;
        if (idle_on && $urandom_range(0, 15) == 0) src_gap = $urandom_range(1, 19);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result sink stall
  always @(negedge clk) begin
    if (!rst_n || !idle_on) begin
      out_stall <= 1'b0;
      snk_gap = 0;
    end else if (snk_gap > 0) begin
      out_stall <= 1'b1;
      snk_gap--;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 11) == 0) snk_gap = $urandom_range(1, 19);
    end
  end

  // monitor and checker
  always @(posedge clk) begin : mon
    dirw_rec_t want;
    if (!rst_n) begin
      in_acc <= 1'b0;
    end else begin
      in_acc <= in_valid && !in_stall;
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (in_valid && !in_stall) begin
        walk_byte(in_data_byte, in_first_byte);
        n_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        buf_len = cfg_buffer_length;
        n_cfg++;
      end
      if (out_valid && !out_stall) begin
        if (entry_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected entry, expected none, actual inode 0x%0h offset 0x%0h",
                   $time, out_entry_inode, out_name_offset);
        end else begin
          want = entry_q.pop_front();
          n_checked++;
          if (out_entry_inode !== want.entry_inode)
            report("entry_inode", want.entry_inode, out_entry_inode);
          if (out_rec_len !== want.rec_len)
            report("rec_len", want.rec_len, out_rec_len);
          if (out_entry_type !== want.entry_type)
            report("entry_type", want.entry_type, out_entry_type);
          if (out_name_length !== want.name_length)
            report("name_length", want.name_length, out_name_length);
          if (out_name_offset !== want.name_offset)
            report("name_offset", want.name_offset, out_name_offset);
        end
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d entries outstanding",
                 $time, quiet, entry_q.size());
        $display("directory_record_walker_core_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic push_byte(logic [7:0] b, logic first);
    dir_byte_t nb;
    nb.data = b;
    nb.first = first;
    pending_bytes.insert(pending_bytes.size(), nb);
  endtask

  task automatic push_header(logic [31:0] ino, logic [15:0] rlen, logic [7:0] typ,
                             logic [7:0] nlen, logic first);
    push_byte(ino[31:24], first);
    push_byte(ino[23:16], 1'b0);
    push_byte(ino[15:8], 1'b0);
    push_byte(ino[7:0], 1'b0);
    push_byte(rlen[15:8], 1'b0);
    push_byte(rlen[7:0], 1'b0);
    push_byte(typ, 1'b0);
    push_byte(nlen, 1'b0);
  endtask

  // one directory buffer: mostly well-formed records, some skipped, stopping or misaligned
  task automatic build_dir(int nbytes);
    int pos;
    int kind;
    int nlen;
    int rlen;
    int unsigned ino;
    pos = 0;
    while (pos < nbytes) begin
      kind = $urandom_range(0, 19);
      nlen = $urandom_range(1, 24);
      if ($urandom_range(0, 7) == 0) nlen = $urandom_range(0, 255);
      ino = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 4000);
      if (kind == 0) nlen = 0;
      if (kind == 1) ino = 0;
      rlen = 8 + ((nlen + 3) & ~3) + 4 * $urandom_range(0, 2);
      if (kind == 2) rlen = 0;
      else if (kind == 3) rlen = $urandom_range(1, 7);
      else if (kind == 4) rlen = $urandom_range(1, 65535);
      else if (kind == 5) rlen = nbytes - pos;
      push_header(ino, 16'(rlen), 8'($urandom), 8'(nlen), pos == 0);
      pos += 8;
      if (kind == 2) rlen = nbytes - pos + 8;
      for (int k = 8; k < rlen && pos < nbytes; k++) begin
        push_byte(8'($urandom), 1'b0);
        pos++;
      end
    end
  endtask

  task automatic add_noise(int n);
    for (int k = 0; k < n; k++)
      push_byte(8'($urandom), $urandom_range(0, 15) == 0);
  endtask

  task automatic write_buf_len(logic [POS_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_buffer_length <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // holds the sender until every byte is taken and every entry has come out
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || n_sent != n_taken || entry_q.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin : stim
    int lens[$];
    int sz;
    lens = '{512, 0, 1, 7, 8, 9, 23, 64, 300, 1048576, 2097151};
    for (int k = 0; k < 3; k++) lens.push_front($urandom_range(10, 700));
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all-ones entry, then a zero record length that stops the walk
    push_header(32'hFFFF_FFFF, 16'h0010, 8'hFF, 8'h01, 1'b1);
    for (int k = 0; k < 8; k++) push_byte(8'h00, 1'b0);
    push_header(32'h0000_0001, 16'h0000, 8'h00, 8'h00, 1'b0);
    push_byte(8'hA5, 1'b0);
    wait_drained();

    foreach (lens[i]) begin
      write_buf_len(POS_W'(lens[i]));
      idle_on = ($urandom_range(0, 3) != 0);
      while (pending_bytes.size() < 60) begin
        if ($urandom_range(0, 5) == 0) begin
          add_noise($urandom_range(1, 16));
        end else begin
          sz = $urandom_range(16, 160);
          if (lens[i] < sz) sz = lens[i] + $urandom_range(1, 6);
          build_dir(sz);
        end
      end
      wait_drained();
    end

    idle_on = 0;
    write_buf_len(POS_W'(512));
    for (int k = 0; k < 3; k++) build_dir($urandom_range(60, 200));
    wait_drained();

    $display("Walked %0d bytes across %0d buffer-length settings; %0d entries checked.",
             n_taken, n_cfg, n_checked);
    if (errors == 0)
      $display("directory_record_walker_core_tb OK");
    else
      $display("directory_record_walker_core_tb NOT OK");
    $finish;
  end

endmodule
